@@ rtl/core/tbwp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbwp_pkg
// Shared types and codes of the text byte wrap pager.
// ----------------------------------------------------------------------------
package tbwp_pkg;

	localparam int FUNC_W     = 2;
	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int PAGE_NUM_W = 6;
	localparam int ROW_NUM_W  = 2;
	localparam int COL_NUM_W  = 5;
	localparam int CHAR_W     = 7;
	localparam int LEN_W      = 6;
	localparam int PCOUNT_W   = 7;
	localparam int HIGH_W     = 16;

	localparam logic [FUNC_W-1:0] FUNC_TEXT    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

	localparam logic [BYTE_W-1:0] CHR_TAB = 8'd9;
	localparam logic [BYTE_W-1:0] CHR_LF  = 8'd10;
	localparam logic [BYTE_W-1:0] CHR_CR  = 8'd13;
	localparam logic [BYTE_W-1:0] CHR_PRINT_LO = 8'd32;
	localparam logic [BYTE_W-1:0] CHR_PRINT_HI = 8'd126;
	localparam logic [CHAR_W-1:0] CHR_SPACE = 7'd32;
	localparam logic [CHAR_W-1:0] CHR_HASH  = 7'd35;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [PAGE_NUM_W-1:0] page_number;
		logic [ROW_NUM_W-1:0]  row_number;
		logic [COL_NUM_W-1:0]  column_number;
		logic [CHAR_W-1:0]     char_code;
		logic [LEN_W-1:0]      line_length;
		logic                  truncated;
		logic [PCOUNT_W-1:0]   page_total;
		logic [HIGH_W-1:0]     non_ascii_count;
		logic                  text_empty;
		logic                  last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       a;
		res_t       b;
	} push_t;

endpackage
`default_nettype wire

@@ rtl/core/tbwp_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbwp interfaces
// Valid/ready channels for text bytes in and layout results out.
// ----------------------------------------------------------------------------
interface tbwp_text_if;
	import tbwp_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [BYTE_W-1:0] byte_value;
	modport source(output valid, func, byte_value, input ready);
	modport sink(input valid, func, byte_value, output ready);
endinterface

interface tbwp_result_if;
	import tbwp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     kind;
	logic [PAGE_NUM_W-1:0] page_number;
	logic [ROW_NUM_W-1:0]  row_number;
	logic [COL_NUM_W-1:0]  column_number;
	logic [CHAR_W-1:0]     char_code;
	logic [LEN_W-1:0]      line_length;
	logic                  truncated;
	logic [PCOUNT_W-1:0]   page_total;
	logic [HIGH_W-1:0]     non_ascii_count;
	logic                  text_empty;
	logic                  last;
	modport source(output valid, kind, page_number, row_number, column_number, char_code,
		line_length, truncated, page_total, non_ascii_count, text_empty, last,
		input ready);
	modport sink(input valid, kind, page_number, row_number, column_number, char_code,
		line_length, truncated, page_total, non_ascii_count, text_empty, last,
		output ready);
endinterface
`default_nettype wire

@@ rtl/core/tbwp_res_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbwp_res_queue
// Four-word result queue: takes up to two words a cycle, gives one while result.ready is high.
// ----------------------------------------------------------------------------
module tbwp_res_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  tbwp_pkg::push_t    push,
	output logic               room,
	tbwp_result_if.source      result
);
	import tbwp_pkg::*;

	res_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                pop;
	res_t                head;

	assign room = (cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
	assign pop  = result.valid && result.ready;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.a;
		if (push.n == 2'd2)
			mem_q[wr_q + QUEUE_AW'(1)] <= push.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QUEUE_AW'(push.n);
			if (pop)
				rd_q <= rd_q + QUEUE_AW'(1);
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push.n) - (QUEUE_AW+1)'(pop);
		end
	end

	assign result.valid           = (cnt_q != '0);
	assign result.kind            = head.kind;
	assign result.page_number     = head.page_number;
	assign result.row_number      = head.row_number;
	assign result.column_number   = head.column_number;
	assign result.char_code       = head.char_code;
	assign result.line_length     = head.line_length;
	assign result.truncated       = head.truncated;
	assign result.page_total      = head.page_total;
	assign result.non_ascii_count = head.non_ascii_count;
	assign result.text_empty      = head.text_empty;
	assign result.last            = head.last;

endmodule
`default_nettype wire

@@ rtl/core/text_byte_wrap_pager.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_byte_wrap_pager
// Lays a text byte stream out into pages of fixed-width lines.
// ----------------------------------------------------------------------------
// A word is taken into an input register, worked on there once the queue has
// room for two words, and its one or two results go into a four-word output
// queue. Input is taken every cycle while the queue has space for two words,
// so the block runs at one byte per cycle; a word that gives two results (a
// wrap, or a finish with an open line) costs more output bandwidth, which the
// single result port sets. Results pass the input register, then the queue.
// ----------------------------------------------------------------------------
module text_byte_wrap_pager #(
	parameter int LINE_CHARS     = 32,
	parameter int LINES_PER_PAGE = 4,
	parameter int PAGE_LIMIT     = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tbwp_text_if.sink     text,
	tbwp_result_if.source result
);
	import tbwp_pkg::*;

	localparam int CW = $clog2(LINE_CHARS + 1);
	localparam int RW = (LINES_PER_PAGE > 1) ? $clog2(LINES_PER_PAGE) : 1;
	localparam int PW = (PAGE_LIMIT > 1) ? $clog2(PAGE_LIMIT) : 1;
	localparam int UW = $clog2(PAGE_LIMIT + 1);

	logic              valid_s1;
	logic [FUNC_W-1:0] func_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [PW-1:0]     page_q, page_d;
	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [CW-1:0]     nse_q, nse_d;
	logic [UW-1:0]     used_q, used_d;
	logic              ovf_q, ovf_d;
	logic [HIGH_W-1:0] high_q, high_d;
	logic [CW-1:0]     first_q, first_d;

	logic          room;
	logic          fire;
	push_t         push;

	logic          is_first, row_last, page_last, wrap;
	logic [PW-1:0] adv_page;
	logic [RW-1:0] adv_row;
	logic [CW-1:0] adv_col, adv_nse;
	logic [UW-1:0] adv_used;
	logic          adv_ovf;
	logic [CW-1:0] base_col;
	logic [CHAR_W-1:0] ch;
	res_t          close_res;

	function automatic logic [CHAR_W-1:0] clean_char(input logic [BYTE_W-1:0] b);
		if (b == CHR_TAB)
			return CHR_SPACE;
		if (b >= CHR_PRINT_LO && b <= CHR_PRINT_HI)
			return b[CHAR_W-1:0];
		return CHR_HASH;
	endfunction

	assign fire       = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (text.ready)
			valid_s1 <= text.valid;
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			func_s1 <= text.func;
			byte_s1 <= text.byte_value;
		end
	end

	// line close and advance
	always_comb begin
		is_first  = (page_q == '0) && (row_q == '0);
		row_last  = (row_q == RW'(LINES_PER_PAGE - 1));
		page_last = (page_q == PW'(PAGE_LIMIT - 1));
		wrap      = (col_q >= CW'(LINE_CHARS));
		adv_ovf   = row_last && page_last;
		adv_page  = page_q;
		adv_row   = row_q + RW'(1);
		adv_col   = '0;
		adv_nse   = '0;
		adv_used  = used_q;
		if (row_last) begin
			adv_row = '0;
			if (page_last) begin
				adv_row = row_q;
				adv_col = nse_q;
				adv_nse = nse_q;
			end else begin
				adv_page = page_q + PW'(1);
				if (used_q < UW'(page_q) + UW'(2))
					adv_used = UW'(page_q) + UW'(2);
			end
		end
		close_res             = '0;
		close_res.kind        = KIND_CLOSE;
		close_res.page_number = PAGE_NUM_W'(page_q);
		close_res.row_number  = ROW_NUM_W'(row_q);
		close_res.line_length = LEN_W'(nse_q);
	end

	always_comb begin
		page_d   = page_q;
		row_d    = row_q;
		col_d    = col_q;
		nse_d    = nse_q;
		used_d   = used_q;
		ovf_d    = ovf_q;
		high_d   = high_q;
		first_d  = first_q;
		push     = '0;
		ch       = clean_char(byte_s1);
		base_col = wrap ? adv_col : col_q;
		if (fire) begin
			case (func_s1)
				FUNC_TEXT: begin
					if (!ovf_q) begin
						if (byte_s1[BYTE_W-1] && high_q != '1)
							high_d = high_q + HIGH_W'(1);
						if (byte_s1 == CHR_LF || (byte_s1 != CHR_CR && wrap)) begin
							page_d = adv_page;
							row_d  = adv_row;
							col_d  = adv_col;
							nse_d  = adv_nse;
							used_d = adv_used;
							ovf_d  = adv_ovf;
							if (is_first)
								first_d = nse_q;
							push.a = close_res;
							push.n = 2'd1;
						end
						if (byte_s1 != CHR_CR && byte_s1 != CHR_LF && !(wrap && adv_ovf)) begin
							col_d = base_col + CW'(1);
							if (ch != CHR_SPACE)
								nse_d = base_col + CW'(1);
							if (push.n == 2'd0) begin
								push.a.kind          = KIND_CHAR;
								push.a.page_number   = PAGE_NUM_W'(page_d);
								push.a.row_number    = ROW_NUM_W'(row_d);
								push.a.column_number = COL_NUM_W'(base_col);
								push.a.char_code     = ch;
							end else begin
								push.b.kind          = KIND_CHAR;
								push.b.page_number   = PAGE_NUM_W'(page_d);
								push.b.row_number    = ROW_NUM_W'(row_d);
								push.b.column_number = COL_NUM_W'(base_col);
								push.b.char_code     = ch;
							end
							push.n = push.n + 2'd1;
						end
					end
				end
				FUNC_FINISH: begin
					if (!ovf_q) begin
						push.a = close_res;
						push.n = 2'd1;
					end
					if (push.n == 2'd0) begin
						push.a.kind            = KIND_FINISH;
						push.a.page_total      = PCOUNT_W'(used_q);
						push.a.non_ascii_count = high_q;
						push.a.text_empty      = is_first ? (nse_q == '0) : (first_q == '0);
					end else begin
						push.b.kind            = KIND_FINISH;
						push.b.page_total      = PCOUNT_W'(used_q);
						push.b.non_ascii_count = high_q;
						push.b.text_empty      = is_first ? (nse_q == '0) : (first_q == '0);
					end
					push.n = push.n + 2'd1;
				end
				FUNC_RESTART: begin
					page_d  = '0;
					row_d   = '0;
					col_d   = '0;
					nse_d   = '0;
					used_d  = UW'(1);
					ovf_d   = 1'b0;
					high_d  = '0;
					first_d = '0;
				end
				default: begin
				end
			endcase
		end
		push.a.truncated = ovf_d;
		push.b.truncated = ovf_d;
		push.a.last      = (push.n == 2'd1);
		push.b.last      = (push.n == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '0;
			row_q   <= '0;
			col_q   <= '0;
			nse_q   <= '0;
			used_q  <= UW'(1);
			ovf_q   <= 1'b0;
			high_q  <= '0;
			first_q <= '0;
		end else begin
			page_q  <= page_d;
			row_q   <= row_d;
			col_q   <= col_d;
			nse_q   <= nse_d;
			used_q  <= used_d;
			ovf_q   <= ovf_d;
			high_q  <= high_d;
			first_q <= first_d;
		end
	end

	tbwp_res_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule
`default_nettype wire
